>>> hw/rtl/swfl_pkg.sv
`timescale 1ns / 1ps

package swfl_pkg;

    localparam int STORE_DEPTH_DEF    = 16;
    localparam int WINDOW_SECONDS_DEF = 60;

    localparam int CMD_W   = 2;
    localparam int TIME_W  = 32;
    localparam int MAXF_W  = 5;
    localparam int LOCKS_W = 17;
    localparam int WAIT_W  = 17;
    localparam int FCNT_W  = 5;
    localparam int CFG_W   = 17;
    localparam int CFG_IDX_W = 1;

    localparam logic [CMD_W-1:0] CMD_CHECK   = 2'd0;
    localparam logic [CMD_W-1:0] CMD_FAILURE = 2'd1;
    localparam logic [CMD_W-1:0] CMD_SUCCESS = 2'd2;

    localparam logic [CFG_IDX_W-1:0] CFG_MAX_FAILURES = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_LOCK_SECONDS = 1'd1;

    localparam logic [MAXF_W-1:0]  MAX_FAILURES_RST = 5'd5;
    localparam logic [LOCKS_W-1:0] LOCK_SECONDS_RST = 17'd60;

    localparam logic [WAIT_W-1:0] WAIT_MAX = 17'h1FFFF;

endpackage

>>> hw/rtl/swfl_in_if.sv
`timescale 1ns / 1ps

interface swfl_in_if;
    import swfl_pkg::*;

    logic              valid;
    logic              ready;
    logic [CMD_W-1:0]  command;
    logic [TIME_W-1:0] now_seconds;

    modport source (output valid, output command, output now_seconds, input ready);
    modport sink (input valid, input command, input now_seconds, output ready);
endinterface

>>> hw/rtl/swfl_out_if.sv
`timescale 1ns / 1ps

interface swfl_out_if;
    import swfl_pkg::*;

    logic              valid;
    logic              ready;
    logic              locked;
    logic [WAIT_W-1:0] wait_seconds;
    logic              lock_started;
    logic [FCNT_W-1:0] failure_count;

    modport source (
        output valid, output locked, output wait_seconds, output lock_started,
        output failure_count, input ready
    );
    modport sink (
        input valid, input locked, input wait_seconds, input lock_started,
        input failure_count, output ready
    );
endinterface

>>> hw/rtl/swfl_cell.sv
`timescale 1ns / 1ps

module swfl_cell #(
    parameter int STORE_DEPTH    = swfl_pkg::STORE_DEPTH_DEF,
    parameter int WINDOW_SECONDS = swfl_pkg::WINDOW_SECONDS_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic [swfl_pkg::TIME_W-1:0] i_now,
    input  logic                        i_clear,
    input  logic                        i_wr,
    input  logic [3*$clog2(STORE_DEPTH)+$clog2(STORE_DEPTH+1)+swfl_pkg::TIME_W+1:0] i_carry,
    output logic [3*$clog2(STORE_DEPTH)+$clog2(STORE_DEPTH+1)+swfl_pkg::TIME_W+1:0] o_carry
);
    import swfl_pkg::*;

    localparam int IDX_W = $clog2(STORE_DEPTH);
    localparam int CNT_W = $clog2(STORE_DEPTH + 1);

    typedef struct packed {
        logic              tok;
        logic [IDX_W-1:0]  pos;
        logic              has_free;
        logic [IDX_W-1:0]  free_idx;
        logic [IDX_W-1:0]  old_idx;
        logic [TIME_W-1:0] old_age;
        logic [CNT_W-1:0]  cnt;
    } t_carry;

    t_carry            w_in;
    t_carry            n_carry;
    t_carry            r_carry;
    logic [TIME_W-1:0] r_time;
    logic              r_valid;
    logic [TIME_W-1:0] w_age;
    logic              w_expire;
    logic              w_live;
    logic              w_has_old;

    assign w_in     = t_carry'(i_carry);
    assign w_age    = i_now - r_time;
    assign w_expire = r_valid && (w_age > TIME_W'(WINDOW_SECONDS));
    assign w_live   = r_valid && !w_expire;
    // an older live entry exists once the count ahead is nonzero
    assign w_has_old = (w_in.cnt != '0);

    always_comb begin
        n_carry     = w_in;
        n_carry.pos = w_in.pos + IDX_W'(1);
        n_carry.cnt = w_in.cnt + CNT_W'(w_live);
        if (!w_live && !w_in.has_free) begin
            n_carry.has_free = 1'b1;
            n_carry.free_idx = w_in.pos;
        end
        if (w_live && (!w_has_old || (w_age > w_in.old_age))) begin
            n_carry.old_idx = w_in.pos;
            n_carry.old_age = w_age;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid     <= 1'b0;
            r_carry.tok <= 1'b0;
        end else begin
            r_carry <= n_carry;
            if (i_clear) begin
                r_valid <= 1'b0;
            end else if (i_wr) begin
                r_valid <= 1'b1;
            end else if (w_in.tok && w_expire) begin
                r_valid <= 1'b0;
            end
        end
        if (i_wr) begin
            r_time <= i_now;
        end
    end

    assign o_carry = r_carry;

endmodule

>>> hw/rtl/sliding_window_failure_lockout_unit.sv
`timescale 1ns / 1ps

// Retry lockout with a sliding window of failure times. A check, success or
// other non-failure transfer gives its result in the next cycle, and the next
// can follow at once if that result is taken. A failure walks a scan token
// down the row of STORE_DEPTH storage cells, one cell per cycle, then decides
// the lockout and stores the time, or clears the cells if a lockout starts.
// Its result is registered as the token leaves the last cell; no transfer is
// taken during the scan. When idle, taking the result frees the input side.
// Config writes are meant for idle periods only.
module sliding_window_failure_lockout_unit #(
    parameter int STORE_DEPTH    = swfl_pkg::STORE_DEPTH_DEF,
    parameter int WINDOW_SECONDS = swfl_pkg::WINDOW_SECONDS_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    swfl_in_if.sink                        i_req,
    swfl_out_if.source                     o_rsp,
    input  logic                           i_cfg_we,
    input  logic [swfl_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [swfl_pkg::CFG_W-1:0]     i_cfg_data
);
    import swfl_pkg::*;

    localparam int IDX_W = $clog2(STORE_DEPTH);
    localparam int CNT_W = $clog2(STORE_DEPTH + 1);
    localparam int TH_W  = (CNT_W > MAXF_W) ? CNT_W : MAXF_W;
    localparam int CAR_W = 3 * IDX_W + CNT_W + TIME_W + 2;
    localparam logic [TH_W-1:0] DEPTH_T = TH_W'(STORE_DEPTH);

    typedef struct packed {
        logic              tok;
        logic [IDX_W-1:0]  pos;
        logic              has_free;
        logic [IDX_W-1:0]  free_idx;
        logic [IDX_W-1:0]  old_idx;
        logic [TIME_W-1:0] old_age;
        logic [CNT_W-1:0]  cnt;
    } t_carry;

    typedef enum logic {
        ST_IDLE,
        ST_SCAN
    } t_state;

    t_state             r_state;
    logic [TIME_W-1:0]  r_now;
    logic               r_start;
    logic [MAXF_W-1:0]  r_max_f;
    logic [LOCKS_W-1:0] r_lock_s;
    logic [TIME_W-1:0]  r_lock_until;
    logic               r_lock_active;
    logic [CNT_W-1:0]   r_count;
    logic               r_o_valid;
    logic               r_o_locked;
    logic [WAIT_W-1:0]  r_o_wait;
    logic               r_o_started;
    logic [FCNT_W-1:0]  r_o_count;

    logic [CAR_W-1:0]       w_chain [STORE_DEPTH+1];
    t_carry                 w_head;
    t_carry                 w_tail;
    logic [STORE_DEPTH-1:0] w_wr;
    logic                   w_clear;
    logic                   w_fire;
    logic                   w_end;
    logic                   w_eval;
    logic [CNT_W-1:0]       w_new_cnt;
    logic [TH_W-1:0]        w_thr;
    logic                   w_started;
    logic [IDX_W-1:0]       w_slot;
    logic [TIME_W-1:0]      w_eval_now;
    logic [TIME_W-1:0]      w_diff;
    logic                   w_act;
    logic                   w_locked;
    logic [WAIT_W-1:0]      w_wait;
    logic [CNT_W-1:0]       w_res_cnt;

    assign i_req.ready = (r_state == ST_IDLE) && (!r_o_valid || o_rsp.ready);
    assign w_fire      = i_req.valid && i_req.ready;

    always_comb begin
        w_head     = '0;
        w_head.tok = r_start;
    end
    assign w_chain[0] = w_head;
    assign w_tail     = t_carry'(w_chain[STORE_DEPTH]);
    assign w_end      = (r_state == ST_SCAN) && w_tail.tok;

    assign w_new_cnt = w_tail.cnt + CNT_W'(w_tail.has_free);
    assign w_thr     = (TH_W'(r_max_f) > DEPTH_T) ? DEPTH_T : TH_W'(r_max_f);
    assign w_started = w_end && (TH_W'(w_new_cnt) >= w_thr);
    assign w_slot    = w_tail.has_free ? w_tail.free_idx : w_tail.old_idx;
    assign w_clear   = w_started ||
                       (w_fire && (i_req.command == CMD_SUCCESS));

    for (genvar k = 0; k < STORE_DEPTH; k++) begin : g_cell
        assign w_wr[k] = w_end && !w_started && (w_slot == IDX_W'(k));

        swfl_cell #(
            .STORE_DEPTH    (STORE_DEPTH),
            .WINDOW_SECONDS (WINDOW_SECONDS)
        ) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_now   (r_now),
            .i_clear (w_clear),
            .i_wr    (w_wr[k]),
            .i_carry (w_chain[k]),
            .o_carry (w_chain[k+1])
        );
    end

    // lockout test runs on the state left by this item
    assign w_eval     = w_end || (w_fire && (i_req.command != CMD_FAILURE));
    assign w_eval_now = (r_state == ST_SCAN) ? r_now : i_req.now_seconds;
    assign w_diff     = w_started ? TIME_W'(r_lock_s) : (r_lock_until - w_eval_now);
    assign w_act      = w_started || r_lock_active;
    assign w_locked   = w_act && (w_diff != '0) && !w_diff[TIME_W-1];

    always_comb begin
        w_wait = '0;
        if (w_locked) begin
            if (w_diff >= TIME_W'(WAIT_MAX)) begin
                w_wait = WAIT_MAX;
            end else begin
                w_wait = w_diff[WAIT_W-1:0] + WAIT_W'(1);
            end
        end
    end

    always_comb begin
        if (w_end) begin
            w_res_cnt = w_started ? '0 : w_new_cnt;
        end else if (i_req.command == CMD_SUCCESS) begin
            w_res_cnt = '0;
        end else begin
            w_res_cnt = r_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= ST_IDLE;
            r_start       <= 1'b0;
            r_max_f       <= MAX_FAILURES_RST;
            r_lock_s      <= LOCK_SECONDS_RST;
            r_lock_until  <= '0;
            r_lock_active <= 1'b0;
            r_count       <= '0;
            r_o_valid     <= 1'b0;
        end else begin
            r_start <= w_fire && (i_req.command == CMD_FAILURE);
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    CFG_MAX_FAILURES: r_max_f  <= i_cfg_data[MAXF_W-1:0];
                    CFG_LOCK_SECONDS: r_lock_s <= i_cfg_data[LOCKS_W-1:0];
                endcase
            end
            unique case (r_state)
                ST_IDLE: begin
                    if (w_fire && (i_req.command == CMD_FAILURE)) begin
                        r_now   <= i_req.now_seconds;
                        r_state <= ST_SCAN;
                    end
                end
                ST_SCAN: begin
                    if (w_end) begin
                        r_state <= ST_IDLE;
                    end
                end
            endcase
            if (w_eval) begin
                r_lock_active <= w_locked;
                if (w_started) begin
                    r_lock_until <= r_now + TIME_W'(r_lock_s);
                end
                r_count     <= w_res_cnt;
                r_o_valid   <= 1'b1;
                r_o_locked  <= w_locked;
                r_o_wait    <= w_wait;
                r_o_started <= w_started;
                r_o_count   <= FCNT_W'(w_res_cnt);
            end else if (o_rsp.ready) begin
                r_o_valid <= 1'b0;
            end
        end
    end

    assign o_rsp.valid         = r_o_valid;
    assign o_rsp.locked        = r_o_locked;
    assign o_rsp.wait_seconds  = r_o_wait;
    assign o_rsp.lock_started  = r_o_started;
    assign o_rsp.failure_count = r_o_count;

endmodule

>>> bench/tb.sv
`timescale 1ns / 1ps

module tb;
    import swfl_pkg::*;

    localparam logic [CMD_W-1:0] CMD_RESERVED = 2'd3;
    localparam int DEPTH        = STORE_DEPTH_DEF;
    localparam int WINDOW       = WINDOW_SECONDS_DEF;
    localparam int SETTLE_TICKS = STORE_DEPTH_DEF + 4;
    localparam int IDLE_PCT     = 37;

    typedef struct packed {
        logic              locked;
        logic [WAIT_W-1:0] wait_s;
        logic              started;
        logic [FCNT_W-1:0] fcount;
    } t_lockout_res;

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 i_cfg_we;
    logic [CFG_IDX_W-1:0] i_cfg_idx;
    logic [CFG_W-1:0]     i_cfg_data;

    swfl_in_if  req_if ();
    swfl_out_if rsp_if ();

    sliding_window_failure_lockout_unit u_top (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_req      (req_if),
        .o_rsp      (rsp_if),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data)
    );

    // predictor state
    logic [TIME_W-1:0]  fail_time [DEPTH];
    bit                 fail_live [DEPTH];
    logic [TIME_W-1:0]  lock_deadline;
    bit                 lock_armed;
    logic [MAXF_W-1:0]  max_fail_cfg;
    logic [LOCKS_W-1:0] lock_len_cfg;

    t_lockout_res lockout_q[$];
    int           err_count;
    bit           idle_on;
    int           stall_request;
    int           stall_left;

    initial i_clk = 1'b0;
    always #1 i_clk = ~i_clk;

    initial begin
        #2000000;
        $display("RESULT: ERROR");
        $finish;
    end

    function automatic int live_count();
        int n;
        n = 0;
        for (int i = 0; i < DEPTH; i++) begin
            if (fail_live[i]) n++;
        end
        return n;
    endfunction

    function automatic void clear_failures();
        for (int i = 0; i < DEPTH; i++) fail_live[i] = 1'b0;
    endfunction

    function automatic void reset_lockout_model();
        clear_failures();
        lock_deadline = '0;
        lock_armed    = 1'b0;
        max_fail_cfg  = MAX_FAILURES_RST;
        lock_len_cfg  = LOCK_SECONDS_RST;
    endfunction

    function automatic t_lockout_res predict_lockout(logic [CMD_W-1:0] cmd,
                                                     logic [TIME_W-1:0] now);
        t_lockout_res      r;
        int                slot;
        int                oldest;
        int                thr;
        bit                any;
        logic [TIME_W-1:0] age;
        logic [TIME_W-1:0] oldest_age;
        logic [TIME_W-1:0] diff;
        r = '0;
        if (cmd == CMD_FAILURE) begin
            for (int i = 0; i < DEPTH; i++) begin
                age = now - fail_time[i];
                if (fail_live[i] && age > TIME_W'(WINDOW)) fail_live[i] = 1'b0;
            end
            slot = -1;
            oldest = 0;
            oldest_age = '0;
            any = 1'b0;
            for (int i = 0; i < DEPTH; i++) begin
                if (!fail_live[i]) begin
                    if (slot < 0) slot = i;
                end else begin
                    age = now - fail_time[i];
                    if (!any || age > oldest_age) begin
                        oldest_age = age;
                        oldest = i;
                        any = 1'b1;
                    end
                end
            end
            if (slot < 0) slot = oldest;
            fail_time[slot] = now;
            fail_live[slot] = 1'b1;
            thr = (int'(max_fail_cfg) > DEPTH) ? DEPTH : int'(max_fail_cfg);
            if (live_count() >= thr) begin
                lock_deadline = now + TIME_W'(lock_len_cfg);
                lock_armed = 1'b1;
                clear_failures();
                r.started = 1'b1;
            end
        end else if (cmd == CMD_SUCCESS) begin
            clear_failures();
        end
        diff = lock_deadline - now;
        if (lock_armed && diff != '0 && diff < 32'h8000_0000) begin
            r.locked = 1'b1;
            r.wait_s = (diff >= TIME_W'(WAIT_MAX)) ? WAIT_MAX : WAIT_W'(diff + 1);
        end else begin
            lock_armed = 1'b0;
        end
        r.fcount = FCNT_W'(live_count());
        return r;
    endfunction

    task automatic note_error(input string msg);
        err_count++;
        if (err_count <= 10) $display("%s", msg);
    endtask

    // result side: ready pattern and long hold-off
    always @(posedge i_clk) begin
        if (stall_request > 0) begin
            stall_left = stall_request;
            stall_request = 0;
        end
        if (!i_rst_n) begin
            rsp_if.ready <= 1'b0;
        end else if (stall_left > 0) begin
            stall_left--;
            rsp_if.ready <= 1'b0;
        end else begin
            rsp_if.ready <= !idle_on || ($urandom_range(99) >= IDLE_PCT);
        end
    end

    always @(posedge i_clk) begin : check_results
        t_lockout_res got;
        t_lockout_res want;
        if (i_rst_n && rsp_if.valid && rsp_if.ready) begin
            got = '{rsp_if.locked, rsp_if.wait_seconds, rsp_if.lock_started,
                    rsp_if.failure_count};
            if (lockout_q.size() == 0) begin
                note_error($sformatf("unexpected transfer at %0t: %p", $realtime, got));
            end else begin
                want = lockout_q.pop_front();
                if (got.locked !== want.locked || got.wait_s !== want.wait_s ||
                    got.started !== want.started || got.fcount !== want.fcount) begin
                    note_error($sformatf("mismatch at %0t: exp %p got %p",
                                         $realtime, want, got));
                end
            end
        end
    end

    task automatic send_item(input logic [CMD_W-1:0] cmd, input logic [TIME_W-1:0] now);
        while (idle_on && $urandom_range(99) < IDLE_PCT) begin
            req_if.valid <= 1'b0;
            @(posedge i_clk);
        end
        req_if.valid       <= 1'b1;
        req_if.command     <= cmd;
        req_if.now_seconds <= now;
        do @(posedge i_clk); while (!req_if.ready);
        lockout_q.insert(lockout_q.size(), predict_lockout(cmd, now));
    endtask

    task automatic drain();
        req_if.valid <= 1'b0;
        while (lockout_q.size() != 0) @(posedge i_clk);
        repeat (SETTLE_TICKS) @(posedge i_clk);
    endtask

    task automatic write_config(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
        drain();
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        if (idx == CFG_MAX_FAILURES) max_fail_cfg = data[MAXF_W-1:0];
        else lock_len_cfg = data[LOCKS_W-1:0];
    endtask

    task automatic test_basic_commands();
        send_item(CMD_CHECK, 32'd0);
        send_item(CMD_RESERVED, 32'hFFFF_FFFF);
        send_item(CMD_SUCCESS, 32'd5);
    endtask

    task automatic test_default_lockout();
        for (int i = 0; i < 5; i++) send_item(CMD_FAILURE, 32'd100 + i);
        send_item(CMD_CHECK, 32'd110);
        send_item(CMD_FAILURE, 32'd120);   // failure while locked
        send_item(CMD_SUCCESS, 32'd130);
        send_item(CMD_CHECK, 32'd164);     // deadline reached
    endtask

    task automatic test_window_edges();
        send_item(CMD_FAILURE, 32'd1000);
        send_item(CMD_FAILURE, 32'd1060);  // age exactly at window, kept
        send_item(CMD_FAILURE, 32'd1121);  // both older ones age out
        send_item(CMD_FAILURE, 32'd1100);  // stored time in the future, dropped
        send_item(CMD_SUCCESS, 32'd1101);
    endtask

    task automatic test_wrap_and_limits();
        write_config(CFG_MAX_FAILURES, CFG_W'(1));
        write_config(CFG_LOCK_SECONDS, CFG_W'(131071));
        send_item(CMD_FAILURE, 32'hFFFF_FFF0);
        send_item(CMD_CHECK, 32'h0000_0010);
        send_item(CMD_CHECK, 32'h8000_0010);  // expired, lock flag drops
        send_item(CMD_CHECK, 32'h0000_0020);  // must stay unlocked
        write_config(CFG_LOCK_SECONDS, CFG_W'(131070));
        send_item(CMD_FAILURE, 32'h1234_5678);
        write_config(CFG_MAX_FAILURES, CFG_W'(0));
        write_config(CFG_LOCK_SECONDS, CFG_W'(0));
        send_item(CMD_FAILURE, 32'd500);
    endtask

    task automatic test_backpressure();
        logic [TIME_W-1:0] t;
        write_config(CFG_MAX_FAILURES, CFG_W'(4));
        write_config(CFG_LOCK_SECONDS, CFG_W'(30));
        t = 32'd5000;
        stall_request = 300;
        for (int i = 0; i < 40; i++) begin
            t += $urandom_range(0, 4);
            send_item((i % 3 == 0) ? CMD_CHECK : CMD_FAILURE, t);
        end
        drain();
    endtask

    task automatic run_random_phase(input int n, input logic [CFG_W-1:0] mf_data,
                                    input logic [CFG_W-1:0] len, input logic [TIME_W-1:0] start,
                                    input bit idle);
        int                sent;
        int                thr;
        int                burst;
        int                r;
        logic [TIME_W-1:0] t;
        write_config(CFG_MAX_FAILURES, mf_data);
        write_config(CFG_LOCK_SECONDS, len);
        idle_on = idle;
        thr = (int'(mf_data[MAXF_W-1:0]) > DEPTH) ? DEPTH : int'(mf_data[MAXF_W-1:0]);
        t = start;
        sent = 0;
        while (sent < n) begin
            r = $urandom_range(99);
            if (r < 55) begin
                burst = $urandom_range(1, thr + 1);
                repeat (burst) begin
                    t += $urandom_range(0, 3);
                    if ($urandom_range(4) == 0) begin
                        send_item(CMD_CHECK, t);
                        sent++;
                    end
                    send_item(CMD_FAILURE, t);
                    sent++;
                end
            end else if (r < 75) begin
                if ($urandom_range(3) == 0) t += $urandom_range(0, int'(len) + 40);
                else t += $urandom_range(0, 20);
                send_item(CMD_CHECK, t);
                sent++;
            end else if (r < 83) begin
                t += $urandom_range(0, 10);
                send_item(CMD_SUCCESS, t);
                sent++;
            end else if (r < 88) begin
                t += $urandom_range(WINDOW + 1, 400);
                send_item(CMD_RESERVED, t);
                sent++;
            end else if (r < 94) begin
                send_item(CMD_FAILURE, t - $urandom_range(1, 100));
                sent++;
            end else begin
                send_item(CMD_W'($urandom_range(3)), $urandom());
                sent++;
            end
        end
        idle_on = 1'b1;
    endtask

    task automatic test_random_traffic();
        run_random_phase(150, CFG_W'(5), CFG_W'(60), 32'd10000, 1'b1);
        run_random_phase(80, CFG_W'(1), CFG_W'(0), $urandom(), 1'b1);
        run_random_phase(60, CFG_W'(0), CFG_W'(17), $urandom(), 1'b1);
        run_random_phase(150, CFG_W'(16), CFG_W'(86400), $urandom(), 1'b1);
        run_random_phase(120, CFG_W'(31), CFG_W'(131071), 32'hFFFF_F000, 1'b1);
        run_random_phase(120, CFG_W'(3), CFG_W'($urandom_range(0, 86400)), $urandom(), 1'b0);
        run_random_phase(120, {12'($urandom()), 5'($urandom_range(1, 16))},
                         CFG_W'($urandom()), $urandom(), 1'b1);
    endtask

    initial begin
        i_rst_n            <= 1'b0;
        req_if.valid       <= 1'b0;
        req_if.command     <= CMD_CHECK;
        req_if.now_seconds <= '0;
        i_cfg_we           <= 1'b0;
        i_cfg_idx          <= CFG_MAX_FAILURES;
        i_cfg_data         <= '0;
        idle_on       = 1'b1;
        stall_request = 0;
        stall_left    = 0;
        err_count     = 0;
        reset_lockout_model();
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_basic_commands();
        test_default_lockout();
        test_window_edges();
        test_wrap_and_limits();
        test_backpressure();
        test_random_traffic();

        drain();
        repeat (40) @(posedge i_clk);
        if (err_count == 0 && lockout_q.size() == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule
